>>> sv/ipd_pkg.sv
// shared types and constants for the pulse-distance decoder
package ipd_pkg;

  localparam int unsigned TICK_W      = 8;
  localparam int unsigned CODE_W      = 32;
  localparam int unsigned INDEX_W     = 6;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_LEADER_MIN    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LEADER_MAX    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_MIN    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_MAX    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BIT_TIMEOUT   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ONE_THRESHOLD = 3'd5;

  // reset values of the registers
  localparam logic [TICK_W-1:0] RST_LEADER_MIN    = 8'd194;
  localparam logic [TICK_W-1:0] RST_LEADER_MAX    = 8'd228;
  localparam logic [TICK_W-1:0] RST_REPEAT_MIN    = 8'd159;
  localparam logic [TICK_W-1:0] RST_REPEAT_MAX    = 8'd193;
  localparam logic [TICK_W-1:0] RST_BIT_TIMEOUT   = 8'd44;
  localparam logic [TICK_W-1:0] RST_ONE_THRESHOLD = 8'd26;

  // bit index: bit 5 set means idle
  localparam logic [INDEX_W-1:0] IDLE_INDEX = 6'd32;
  localparam logic [INDEX_W-1:0] LAST_INDEX = 6'd31;

  typedef struct packed {
    logic [TICK_W-1:0] leader_min;
    logic [TICK_W-1:0] leader_max;
    logic [TICK_W-1:0] repeat_min;
    logic [TICK_W-1:0] repeat_max;
    logic [TICK_W-1:0] bit_timeout;
    logic [TICK_W-1:0] one_threshold;
  } cfg_t;

  // classified edge as handed from front to back
  typedef struct packed {
    logic ovf;
    logic leader_hit;
    logic repeat_hit;
    logic abort;
    logic one;
  } edge_class_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

>>> sv/ipd_front.sv
// front end: compares each edge interval against the configured windows, timeout and one threshold
module ipd_front (
  input  logic [ipd_pkg::TICK_W-1:0] interval,
  input  logic                       overflow,
  input  ipd_pkg::cfg_t              cfg,
  output ipd_pkg::edge_class_t       cls
);
  import ipd_pkg::*;

  always_comb begin
    cls.ovf        = overflow;
    cls.leader_hit = (interval >= cfg.leader_min) && (interval <= cfg.leader_max);
    cls.repeat_hit = (interval >= cfg.repeat_min) && (interval <= cfg.repeat_max);
    cls.abort      = overflow || (interval > cfg.bit_timeout);
    cls.one        = interval > cfg.one_threshold;
  end

endmodule

>>> sv/ipd_queue.sv
// small fifo of classified edges between front and back
module ipd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ipd_pkg::edge_class_t push_data,
  input  logic                 pop,
  output ipd_pkg::edge_class_t pop_data,
  output ipd_pkg::q_stat_t     stat
);
  import ipd_pkg::*;

  edge_class_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [QCNT_W-1:0]       count;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/ipd_back.sv
// back end: frame state, bit assembly and the result register
module ipd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  ipd_pkg::edge_class_t        cls,
  input  ipd_pkg::q_stat_t            q_stat,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ipd_pkg::CODE_W-1:0]  code,
  output logic                        is_repeat
);
  import ipd_pkg::*;

  logic [INDEX_W-1:0] bit_index;
  logic [INDEX_W-1:0] bit_index_next;
  logic [CODE_W-1:0]  frame_bits;
  logic [CODE_W-1:0]  frame_bits_next;
  logic               emit;
  logic               emit_repeat;

  // take an edge whenever the result register is free or being drained
  assign pop = !q_stat.empty && (!out_valid || !out_stall);

  always_comb begin
    bit_index_next  = bit_index;
    frame_bits_next = frame_bits;
    emit            = 1'b0;
    emit_repeat     = 1'b0;
    if (pop) begin
      if (bit_index[INDEX_W-1]) begin
        // idle: look for leader or repeat
        bit_index_next = IDLE_INDEX;
        if (!cls.ovf) begin
          if (cls.leader_hit) begin
            frame_bits_next = '0;
            bit_index_next  = '0;
          end else if (cls.repeat_hit) begin
            emit        = 1'b1;
            emit_repeat = 1'b1;
          end
        end
      end else if (cls.abort) begin
        bit_index_next = IDLE_INDEX;
      end else begin
        if (cls.one) begin
          frame_bits_next[bit_index[INDEX_W-2:0]] = 1'b1;
        end
        if (bit_index == LAST_INDEX) begin
          bit_index_next = IDLE_INDEX;
          emit           = 1'b1;
        end else begin
          bit_index_next = bit_index + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_index  <= IDLE_INDEX;
      frame_bits <= '0;
      out_valid  <= 1'b0;
    end else begin
      bit_index  <= bit_index_next;
      frame_bits <= frame_bits_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      code      <= frame_bits_next;
      is_repeat <= emit_repeat;
    end
  end

endmodule

>>> sv/ir_pulse_distance_decoder.sv
// top level of the pulse-distance ir frame decoder
// a completing edge goes through the edge queue; the result is registered when it is popped
// throughput: one edge per cycle, limited only by the two-entry edge queue and result register
// reset: synchronous, active high; decoder idle, data word zero, queue empty
// reset restores the register defaults 194/228/159/193/44/26
module ir_pulse_distance_decoder (
  input  logic                          clk,
  input  logic                          rst,
  // edge channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ipd_pkg::TICK_W-1:0]    interval,
  input  logic                          overflow,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ipd_pkg::CODE_W-1:0]    code,
  output logic                          is_repeat,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ipd_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [ipd_pkg::TICK_W-1:0]    cfg_data
);
  import ipd_pkg::*;

  cfg_t        cfg;
  edge_class_t front_cls;
  edge_class_t back_cls;
  q_stat_t     q_stat;
  logic        push;
  logic        pop;

  // register writes are always taken; cfg_ready is tied high
  assign cfg_ready = 1'b1;

  // config register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_min    <= RST_LEADER_MIN;
      cfg.leader_max    <= RST_LEADER_MAX;
      cfg.repeat_min    <= RST_REPEAT_MIN;
      cfg.repeat_max    <= RST_REPEAT_MAX;
      cfg.bit_timeout   <= RST_BIT_TIMEOUT;
      cfg.one_threshold <= RST_ONE_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEADER_MIN:    cfg.leader_min    <= cfg_data;
        REG_LEADER_MAX:    cfg.leader_max    <= cfg_data;
        REG_REPEAT_MIN:    cfg.repeat_min    <= cfg_data;
        REG_REPEAT_MAX:    cfg.repeat_max    <= cfg_data;
        REG_BIT_TIMEOUT:   cfg.bit_timeout   <= cfg_data;
        REG_ONE_THRESHOLD: cfg.one_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // edges are held off only when the queue is full
  assign in_stall = q_stat.full;
  assign push     = in_valid && !in_stall;

  // front: window and threshold compares on the incoming edge
  ipd_front u_front (
    .interval (interval),
    .overflow (overflow),
    .cfg      (cfg),
    .cls      (front_cls)
  );

  // queue decouples edge acceptance from result back-pressure
  ipd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cls),
    .pop       (pop),
    .pop_data  (back_cls),
    .stat      (q_stat)
  );

  // back: frame tracking and result register
  ipd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cls       (back_cls),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code      (code),
    .is_repeat (is_repeat)
  );

  // queue cannot report full and empty at once
  a_q_status: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty together");

  // back never reads an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // a transferred edge is in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push |=> !q_stat.empty)
    else $error("transferred edge lost");

  // a held result blocks further pops
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !pop)
    else $error("pop while result is stalled");

endmodule

>>> verif/ir_decode_checker.sv
// checker for the pulse-distance decoder: predicts results from accepted edges and compares
`timescale 1ns / 1ps
module ir_decode_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [ipd_pkg::TICK_W-1:0]     interval,
  input  logic                           overflow,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [ipd_pkg::CODE_W-1:0]     code,
  input  logic                           is_repeat,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ipd_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [ipd_pkg::TICK_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             frames_seen,
  output int                             repeats_seen
);
  import ipd_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0] word;
    logic              repeat_flag;
  } ir_result_t;

  cfg_t               regs;
  logic [INDEX_W-1:0] bit_pos;
  logic [CODE_W-1:0]  frame_word;
  ir_result_t         expected_codes[$];
  int                 errs = 0;
  int                 n_frames = 0;
  int                 n_repeats = 0;

  // one falling edge through the decoder; returns 1 when it yields a result
  function automatic logic decode_edge(input logic [TICK_W-1:0] ticks, input logic ovf,
                                       output ir_result_t res);
    res = '0;
    if (bit_pos[INDEX_W-1]) begin
      bit_pos = IDLE_INDEX;
      if (ovf) return 1'b0;
      if (ticks >= regs.leader_min && ticks <= regs.leader_max) begin
        frame_word = '0;
        bit_pos = '0;
        return 1'b0;
      end
      if (ticks >= regs.repeat_min && ticks <= regs.repeat_max) begin
        res = '{frame_word, 1'b1};
        return 1'b1;
      end
      return 1'b0;
    end
    if (ovf || ticks > regs.bit_timeout) begin
      bit_pos = IDLE_INDEX;
      return 1'b0;
    end
    if (ticks > regs.one_threshold) frame_word[bit_pos[4:0]] = 1'b1;
    if (bit_pos == LAST_INDEX) begin
      bit_pos = IDLE_INDEX;
      res = '{frame_word, 1'b0};
      return 1'b1;
    end
    bit_pos = bit_pos + 1'b1;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    ir_result_t got;
    ir_result_t want;
    if (rst) begin
      regs = '{RST_LEADER_MIN, RST_LEADER_MAX, RST_REPEAT_MIN, RST_REPEAT_MAX,
               RST_BIT_TIMEOUT, RST_ONE_THRESHOLD};
      bit_pos = IDLE_INDEX;
      frame_word = '0;
      expected_codes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LEADER_MIN:    regs.leader_min = cfg_data;
          REG_LEADER_MAX:    regs.leader_max = cfg_data;
          REG_REPEAT_MIN:    regs.repeat_min = cfg_data;
          REG_REPEAT_MAX:    regs.repeat_max = cfg_data;
          REG_BIT_TIMEOUT:   regs.bit_timeout = cfg_data;
          REG_ONE_THRESHOLD: regs.one_threshold = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{code, is_repeat};
        if (got.repeat_flag) n_repeats++;
        else n_frames++;
        if (expected_codes.size() == 0) begin
          errs++;
          $display("%0t: unexpected result: expected none, actual code %h is_repeat %b",
                   $time, code, is_repeat);
        end else begin
          want = expected_codes.pop_front();
          if (got.word !== want.word) begin
            errs++;
            $display("%0t: code mismatch: expected %h, actual %h", $time, want.word, got.word);
          end
          if (got.repeat_flag !== want.repeat_flag) begin
            errs++;
            $display("%0t: is_repeat mismatch: expected %b, actual %b",
                     $time, want.repeat_flag, got.repeat_flag);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (decode_edge(interval, overflow, want)) expected_codes.push_back(want);
      end
    end
    fail_count <= errs;
    pending <= expected_codes.size();
    frames_seen <= n_frames;
    repeats_seen <= n_repeats;
  end

endmodule

>>> verif/tb_ir_pulse_distance_decoder.sv
// testbench top for the pulse-distance decoder: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb_ir_pulse_distance_decoder;
  import ipd_pkg::*;

  localparam int PHASE_BUDGET   = 130;   // edges per register setting
  localparam int HOLD_CYCLES    = 150;   // long receiver hold-off
  localparam int PRESSURE_EDGES = 40;    // repeat edges offered during the hold-off
  localparam int SETTLE_CYCLES  = 8;     // covers the registered result and the edge queue, with margin
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on any channel

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [TICK_W-1:0]     interval;
  logic                  overflow;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CODE_W-1:0]     code;
  logic                  is_repeat;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [TICK_W-1:0]     cfg_data;

  int fail_count;
  int pending;
  int frames_seen;
  int repeats_seen;

  cfg_t active_regs;        // setting in force, used only to shape stimulus
  cfg_t plan[$];
  logic idle_on = 1'b0;     // random gaps on both sides when set
  int   hold_req = 0;       // bumped by the sender to ask for a long hold-off
  int   hold_seen = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   edges_sent = 0;
  int   settings_run = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  ir_pulse_distance_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .interval  (interval),
    .overflow  (overflow),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code      (code),
    .is_repeat (is_repeat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ir_decode_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .interval     (interval),
    .overflow     (overflow),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .code         (code),
    .is_repeat    (is_repeat),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .frames_seen  (frames_seen),
    .repeats_seen (repeats_seen)
  );

  // mostly no pause, often a short one, now and then a long one
  function automatic int random_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // value inside a window, or anything at all when the window is empty
  function automatic logic [TICK_W-1:0] pick_in(input logic [TICK_W-1:0] lo,
                                                input logic [TICK_W-1:0] hi);
    if (lo <= hi) return TICK_W'($urandom_range(hi, lo));
    return TICK_W'($urandom_range(0, 255));
  endfunction

  function automatic cfg_t make_regs(input int lmin, input int lmax, input int rmin,
                                     input int rmax, input int tmo, input int thr);
    cfg_t c;
    c.leader_min    = TICK_W'(lmin);
    c.leader_max    = TICK_W'(lmax);
    c.repeat_min    = TICK_W'(rmin);
    c.repeat_max    = TICK_W'(rmax);
    c.bit_timeout   = TICK_W'(tmo);
    c.one_threshold = TICK_W'(thr);
    return c;
  endfunction

  // result side: random stalls, plus a long hold-off whenever the sender asks for one
  always @(posedge clk) begin
    int n;
    n = random_pause();
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      stall_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && n > 0) begin
      stall_left = n - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog: a run that stops moving is a failure
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // one edge transfer; valid stays high afterwards so a zero gap keeps the stream dense
  task automatic send_edge(input logic [TICK_W-1:0] t, input logic o);
    int gap;
    gap = idle_on ? random_pause() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    interval <= t;
    overflow <= o;
    do @(posedge clk); while (in_stall);
    edges_sent++;
  endtask

  // drop valid, let every expected result drain, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [TICK_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // registers change only once every expected result has drained and nothing is in flight
  task automatic load_regs(input cfg_t c);
    wait_idle();
    cfg_valid <= 1'b1;
    put_reg(REG_LEADER_MIN, c.leader_min);
    put_reg(REG_LEADER_MAX, c.leader_max);
    put_reg(REG_REPEAT_MIN, c.repeat_min);
    put_reg(REG_REPEAT_MAX, c.repeat_max);
    put_reg(REG_BIT_TIMEOUT, c.bit_timeout);
    put_reg(REG_ONE_THRESHOLD, c.one_threshold);
    cfg_valid <= 1'b0;
    active_regs = c;
    settings_run++;
  endtask

  // data interval that kills the frame: too long, or a timer wrap
  task automatic send_abort();
    if (active_regs.bit_timeout < 8'd255 && $urandom_range(0, 1))
      send_edge(TICK_W'($urandom_range(255, active_regs.bit_timeout + 1)), 1'b0);
    else
      send_edge(TICK_W'($urandom_range(0, 255)), 1'b1);
  endtask

  // leader plus 32 data bits with random content; a few frames get cut short
  task automatic send_frame();
    logic [TICK_W-1:0] zero_hi;
    logic              ones_ok;
    zero_hi = (active_regs.one_threshold < active_regs.bit_timeout) ?
              active_regs.one_threshold : active_regs.bit_timeout;
    ones_ok = active_regs.one_threshold < active_regs.bit_timeout;
    send_edge(pick_in(active_regs.leader_min, active_regs.leader_max), 1'b0);
    for (int i = 0; i < 32; i++) begin
      if ($urandom_range(0, 149) == 0) begin
        send_abort();
        break;
      end
      if (ones_ok && $urandom_range(0, 1))
        send_edge(TICK_W'($urandom_range(active_regs.bit_timeout,
                                         active_regs.one_threshold + 1)), 1'b0);
      else
        send_edge(TICK_W'($urandom_range(zero_hi, 0)), 1'b0);
    end
  endtask

  // random traffic under the current setting: mostly frames, some repeats, some broken frames, some noise
  task automatic run_phase(input int budget);
    int start;
    int kind;
    start = edges_sent;
    while (edges_sent - start < budget) begin
      idle_on <= ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        send_frame();
      end else if (kind < 7) begin
        send_edge(pick_in(active_regs.repeat_min, active_regs.repeat_max), 1'b0);
      end else if (kind < 8) begin
        // leader followed by a broken tail
        send_edge(pick_in(active_regs.leader_min, active_regs.leader_max), 1'b0);
        repeat ($urandom_range(0, 5))
          send_edge(TICK_W'($urandom_range(0, active_regs.one_threshold)), 1'b0);
        send_abort();
      end else begin
        send_edge(TICK_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  // edges around the reset windows and thresholds
  task automatic run_directed();
    send_edge(RST_REPEAT_MIN, 1'b0);                  // repeat before any frame: word still zero
    send_edge(RST_LEADER_MIN, 1'b1);                  // overflow while idle is ignored
    send_edge(8'd0, 1'b0);                            // idle, in neither window
    send_edge(8'hff, 1'b0);
    send_edge(8'hff, 1'b1);
    send_edge(TICK_W'(RST_LEADER_MAX + 1), 1'b0);     // just outside the leader window
    send_edge(TICK_W'(RST_REPEAT_MIN - 1), 1'b0);     // just outside the repeat window
    send_edge(RST_LEADER_MIN, 1'b0);                  // frame start at the low window edge
    send_edge(8'd0, 1'b0);                            // shortest zero
    send_edge(RST_ONE_THRESHOLD, 1'b0);               // at threshold: still a zero
    send_edge(TICK_W'(RST_ONE_THRESHOLD + 1), 1'b0);  // just above: a one
    send_edge(RST_BIT_TIMEOUT, 1'b0);                 // at timeout: a one, no abort
    send_edge(TICK_W'(RST_BIT_TIMEOUT + 1), 1'b0);    // past timeout: abort
    send_edge(RST_REPEAT_MAX, 1'b0);                  // repeat carries the partial bits
    send_edge(RST_LEADER_MAX, 1'b0);                  // frame start at the high window edge
    send_edge(TICK_W'(RST_ONE_THRESHOLD + 1), 1'b1);  // overflow inside a frame aborts
    send_edge(TICK_W'(RST_REPEAT_MIN + 10), 1'b0);    // leader cleared the word, so zero again
  endtask

  // receiver holds off while the sender streams repeats, so the block backs up
  task automatic apply_pressure();
    idle_on <= 1'b0;
    wait_idle();
    hold_req <= hold_req + 1;
    repeat (PRESSURE_EDGES) send_edge(RST_REPEAT_MIN, 1'b0);
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    interval = '0;
    overflow = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    active_regs = make_regs(RST_LEADER_MIN, RST_LEADER_MAX, RST_REPEAT_MIN, RST_REPEAT_MAX,
                            RST_BIT_TIMEOUT, RST_ONE_THRESHOLD);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    settings_run = 1;

    run_directed();
    apply_pressure();
    run_phase(PHASE_BUDGET);

    // settings: all-zero and all-one extremes, overlapping windows, an empty leader
    // window, threshold above timeout, two random ones, and back to the defaults
    plan.push_back(make_regs(0, 0, 0, 0, 0, 0));
    plan.push_back(make_regs(255, 255, 255, 255, 255, 255));
    plan.push_back(make_regs(100, 200, 150, 250, 60, 30));
    plan.push_back(make_regs(200, 100, 50, 80, 40, 20));
    plan.push_back(make_regs(194, 228, 159, 193, 20, 200));
    repeat (2) begin
      int lmin;
      int rmin;
      int tmo;
      lmin = $urandom_range(130, 200);
      rmin = $urandom_range(60, 129);
      tmo = $urandom_range(10, 99);
      plan.push_back(make_regs(lmin, lmin + $urandom_range(0, 55), rmin,
                               rmin + $urandom_range(0, 40), tmo, $urandom_range(0, tmo)));
    end
    plan.push_back(make_regs(RST_LEADER_MIN, RST_LEADER_MAX, RST_REPEAT_MIN, RST_REPEAT_MAX,
                             RST_BIT_TIMEOUT, RST_ONE_THRESHOLD));
    foreach (plan[i]) begin
      load_regs(plan[i]);
      run_phase(PHASE_BUDGET);
    end

    wait_idle();
    $display("run covered %0d edges under %0d register settings, %0d full frames and %0d repeats",
             edges_sent, settings_run, frames_seen, repeats_seen);
    $display("including window and threshold extremes, aborted frames and a long result hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
